>>> rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tick driven task slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int CODE_W       = 16;
  localparam int DELAY_W      = 16;
  localparam int PEND_W       = 8;
  localparam int SLOT_W       = 6;
  localparam int RESULT_LIMIT = 8;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 24;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELETE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_WALK,
    S_DSP_WALK,
    S_DSP_END
  } state_t;

  // broadcast from the controller to every slot cell
  typedef struct packed {
    logic                tick;
    logic                shift;
    logic                flush;
    logic                write;
    logic                take;
    logic                del;
    logic [SLOT_W-1:0]   slot_index;
    logic [CODE_W-1:0]   code;
    logic [DELAY_W-1:0]  delay;
    logic [DELAY_W-1:0]  period;
  } cell_ctl_t;

  // per-cell view, token-qualified except sel_occ
  typedef struct packed {
    logic                occupied;
    logic                due;
    logic                sel_occ;
    logic [CODE_W-1:0]   code;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tick_driven_task_slot_scheduler_top.sv
// ----------------------------------------------------------------------------
// tick_driven_task_slot_scheduler_top
// Time triggered cooperative task scheduler built as a row of slot cells.
// ----------------------------------------------------------------------------
// Requests are taken one at a time, once the result register is empty. Tick
// acts on all slot cells at once and delete on the addressed cell; both
// present their result in the cycle after the request. Add and dispatch send
// a token down the row of slot cells, one cell per cycle while dispatch is
// not held up by a result that waits for tready. Dispatch gives at most eight
// results, one per due slot in slot order, or one none result if no slot is
// due; the last one carries tlast.
`default_nettype none

module tick_driven_task_slot_scheduler_top #(
  parameter int TASK_SLOTS = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // task_code[15:0], first_delay[31:16], repeat_period[47:32],
  // slot_index[53:48], zero[55:54]
  input  wire  [tts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  wire  [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // slot[5:0], due_code[21:6], zero[23:22]
  output logic [tts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  tts_pkg::cell_ctl_t   ctl;
  tts_pkg::cell_stat_t  stat;
  tts_pkg::cell_stat_t  cell_stat [TASK_SLOTS];
  logic                 tok_chain [TASK_SLOTS];
  logic                 tok_start;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    tts_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  ((i == 0) ? tok_start : tok_chain[(i == 0) ? 0 : i - 1]),
      .tok_out (tok_chain[i]),
      .stat    (cell_stat[i])
    );
  end

  // only the token holder (or the delete target) drives nonzero
  always_comb begin
    stat = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      stat = tts_pkg::cell_stat_t'(stat | cell_stat[i]);
    end
  end

  tts_ctrl #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .ctl           (ctl),
    .tok_start     (tok_start),
    .stat          (stat)
  );

endmodule

`default_nettype wire

>>> rtl/core/tts_cell.sv
// ----------------------------------------------------------------------------
// tts_cell
// One task slot: holds code, delay, period and pending runs, and passes the
// walk token on to the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell #(
  parameter int INDEX = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  tts_pkg::cell_ctl_t  ctl,
  input  wire                 tok_in,
  output logic                tok_out,
  output tts_pkg::cell_stat_t stat
);

  logic                           tok;
  logic                           occupied;
  logic [tts_pkg::PEND_W-1:0]     pending;
  logic [tts_pkg::CODE_W-1:0]     code;
  logic [tts_pkg::DELAY_W-1:0]    delay;
  logic [tts_pkg::DELAY_W-1:0]    period;
  logic                           del_hit;
  logic                           fire;

  assign del_hit = ctl.del && (ctl.slot_index == tts_pkg::SLOT_W'(INDEX));
  assign fire    = ctl.tick && occupied && (delay == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok      <= 1'b0;
      occupied <= 1'b0;
      pending  <= '0;
    end else begin
      if (ctl.flush) begin
        tok <= 1'b0;
      end else if (ctl.shift) begin
        tok <= tok_in;
      end
      if (fire && pending != '1) begin
        pending <= pending + 1'b1;
      end
      if (ctl.write && tok) begin
        occupied <= 1'b1;
        pending  <= '0;
      end
      if (ctl.take && tok) begin
        // one-shot task leaves the table once run
        if (period == '0) begin
          occupied <= 1'b0;
          pending  <= '0;
        end else begin
          pending <= pending - 1'b1;
        end
      end
      if (del_hit) begin
        occupied <= 1'b0;
        pending  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write && tok) begin
      code   <= ctl.code;
      delay  <= ctl.delay;
      period <= ctl.period;
    end else if (ctl.tick && occupied) begin
      if (delay == '0) begin
        if (period != '0) begin
          delay <= period;
        end
      end else begin
        delay <= delay - 1'b1;
      end
    end
  end

  assign tok_out       = tok;
  assign stat.occupied = tok && occupied;
  assign stat.due      = tok && occupied && (pending != '0);
  assign stat.sel_occ  = del_hit && occupied;
  assign stat.code     = tok ? code : '0;

endmodule

`default_nettype wire

>>> rtl/core/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Request decode, token walk sequencing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl #(
  parameter int TASK_SLOTS = 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [tts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire  [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  output tts_pkg::cell_ctl_t                 ctl,
  output logic                               tok_start,
  input  tts_pkg::cell_stat_t                stat
);

  localparam int POS_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  tts_pkg::state_t                 state, state_next;
  logic [POS_W-1:0]                pos;
  logic [tts_pkg::CNT_W-1:0]       cnt;
  logic [tts_pkg::CODE_W-1:0]      code_r;
  logic [tts_pkg::DELAY_W-1:0]     delay_r;
  logic [tts_pkg::DELAY_W-1:0]     period_r;

  logic                            out_valid;
  tts_pkg::status_t                out_status;
  logic [tts_pkg::SLOT_W-1:0]      out_slot;
  logic [tts_pkg::CODE_W-1:0]      out_code;
  logic                            out_last;

  logic                            hold_valid;
  logic [tts_pkg::SLOT_W-1:0]      hold_slot;
  logic [tts_pkg::CODE_W-1:0]      hold_code;

  logic                            accept;
  tts_pkg::opcode_t                op;
  logic [tts_pkg::SLOT_W-1:0]      in_slot;
  logic                            at_end;
  logic                            out_free;
  logic [tts_pkg::SLOT_W-1:0]      pos_slot;

  logic                            load_out;
  tts_pkg::status_t                out_status_next;
  logic [tts_pkg::SLOT_W-1:0]      out_slot_next;
  logic [tts_pkg::CODE_W-1:0]      out_code_next;
  logic                            out_last_next;
  logic                            emit;
  logic                            hold_clear;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign op       = tts_pkg::opcode_t'(s_axis_tuser);
  assign in_slot  = s_axis_tdata[53:48];
  assign at_end   = (pos == POS_W'(TASK_SLOTS - 1));
  assign out_free = !out_valid || m_axis_tready;
  assign pos_slot = tts_pkg::SLOT_W'(pos);

  assign s_axis_tready = (state == tts_pkg::S_IDLE) && !out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tts_pkg::S_IDLE: begin
        if (accept && op == tts_pkg::OP_ADD) begin
          state_next = tts_pkg::S_ADD_WALK;
        end else if (accept && op == tts_pkg::OP_DISPATCH) begin
          state_next = tts_pkg::S_DSP_WALK;
        end
      end
      tts_pkg::S_ADD_WALK: begin
        if (ctl.flush) begin
          state_next = tts_pkg::S_IDLE;
        end
      end
      tts_pkg::S_DSP_WALK: begin
        if (ctl.flush) begin
          state_next = tts_pkg::S_DSP_END;
        end
      end
      tts_pkg::S_DSP_END: begin
        if (out_free) begin
          state_next = tts_pkg::S_IDLE;
        end
      end
      default: state_next = tts_pkg::S_IDLE;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    ctl             = '0;
    ctl.code        = code_r;
    ctl.delay       = delay_r;
    ctl.period      = period_r;
    ctl.slot_index  = in_slot;
    tok_start       = 1'b0;
    load_out        = 1'b0;
    out_status_next = tts_pkg::ST_OK;
    out_slot_next   = '0;
    out_code_next   = '0;
    out_last_next   = 1'b1;
    emit            = 1'b0;
    hold_clear      = 1'b0;
    unique case (state)
      tts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            tts_pkg::OP_TICK: begin
              ctl.tick = 1'b1;
              load_out = 1'b1;
            end
            tts_pkg::OP_DELETE: begin
              ctl.del         = 1'b1;
              load_out        = 1'b1;
              out_status_next = stat.sel_occ ? tts_pkg::ST_OK : tts_pkg::ST_EMPTY;
              out_slot_next   = in_slot;
            end
            tts_pkg::OP_ADD, tts_pkg::OP_DISPATCH: begin
              tok_start = 1'b1;
              ctl.shift = 1'b1;
            end
            default: ;
          endcase
        end
      end
      tts_pkg::S_ADD_WALK: begin
        if (!stat.occupied) begin
          ctl.write     = 1'b1;
          ctl.flush     = 1'b1;
          load_out      = 1'b1;
          out_slot_next = pos_slot;
        end else if (at_end) begin
          ctl.flush       = 1'b1;
          load_out        = 1'b1;
          out_status_next = tts_pkg::ST_FULL;
        end else begin
          ctl.shift = 1'b1;
        end
      end
      tts_pkg::S_DSP_WALK: begin
        if (stat.due) begin
          if (!hold_valid) begin
            emit = 1'b1;
          end else if (out_free) begin
            // previous due slot goes out, it is not the final one
            emit          = 1'b1;
            load_out      = 1'b1;
            out_slot_next = hold_slot;
            out_code_next = hold_code;
            out_last_next = 1'b0;
          end
        end
        ctl.take = emit;
        if (emit || !stat.due) begin
          if ((emit && cnt == tts_pkg::CNT_W'(tts_pkg::RESULT_LIMIT - 1)) || at_end) begin
            ctl.flush = 1'b1;
          end else begin
            ctl.shift = 1'b1;
          end
        end
      end
      tts_pkg::S_DSP_END: begin
        if (out_free) begin
          load_out   = 1'b1;
          hold_clear = 1'b1;
          if (hold_valid) begin
            out_slot_next = hold_slot;
            out_code_next = hold_code;
          end else begin
            out_status_next = tts_pkg::ST_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tts_pkg::S_IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (hold_clear) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= out_status_next;
      out_slot   <= out_slot_next;
      out_code   <= out_code_next;
      out_last   <= out_last_next;
    end
    if (emit) begin
      hold_slot <= pos_slot;
      hold_code <= stat.code;
    end
    if (tok_start) begin
      pos <= '0;
      cnt <= '0;
    end else begin
      if (ctl.shift) begin
        pos <= pos + 1'b1;
      end
      if (emit) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (accept && op == tts_pkg::OP_ADD) begin
      code_r   <= s_axis_tdata[15:0];
      delay_r  <= s_axis_tdata[31:16];
      period_r <= s_axis_tdata[47:32];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_code, out_slot};

endmodule

`default_nettype wire

>>> rtl/core/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks for the task slot scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire [1:0]                       s_axis_tuser,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [tts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire [1:0]                       m_axis_tuser,
  input wire                             m_axis_tlast
);

  // a new request is only taken with the result register empty
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while a result is pending");

  // tick and delete answer on the next cycle
  a_single_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == tts_pkg::OP_TICK || s_axis_tuser == tts_pkg::OP_DELETE))
    |=> m_axis_tvalid)
    else $error("tick or delete result missing");

  // every non-ok status ends its request
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != tts_pkg::ST_OK) |-> m_axis_tlast)
    else $error("error status without tlast");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind tick_driven_task_slot_scheduler_top tts_checker u_tts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
